>>> design/avgpd_pkg.sv
package avgpd_pkg;

  localparam int DATA_W                = 64;
  localparam int ELEM_SIZE_W           = 2;
  localparam int ROW_WIDTH_W           = 13;
  localparam int CFG_INDEX_W           = 1;
  localparam int DEFAULT_MAX_ROW_WIDTH = 4096;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ELEMENT_SIZE = 1'b0,
    REG_ROW_WIDTH    = 1'b1
  } reg_index_t;

  typedef enum logic [ELEM_SIZE_W-1:0] {
    ES_8  = 2'd0,
    ES_16 = 2'd1,
    ES_32 = 2'd2,
    ES_64 = 2'd3
  } elem_size_t;

  // per-element position flags handed from the column tracker to the datapath
  typedef struct packed {
    logic use_n;
    logic use_w;
    logic store;
  } pos_t;

  function automatic logic [DATA_W-1:0] width_mask(input logic [ELEM_SIZE_W-1:0] es);
    logic [DATA_W-1:0] m;
    case (elem_size_t'(es))
      ES_8:    m = 64'h0000_0000_0000_00FF;
      ES_16:   m = 64'h0000_0000_0000_FFFF;
      ES_32:   m = 64'h0000_0000_FFFF_FFFF;
      ES_64:   m = 64'hFFFF_FFFF_FFFF_FFFF;
      default: m = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

>>> design/avgpd_ram.sv
module avgpd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> design/avgpd_ctrl.sv
module avgpd_ctrl
  import avgpd_pkg::*;
#(
  parameter int MAX_ROW_WIDTH = DEFAULT_MAX_ROW_WIDTH,
  localparam int AW   = (MAX_ROW_WIDTH > 1) ? $clog2(MAX_ROW_WIDTH) : 1,
  localparam int CW   = $clog2(MAX_ROW_WIDTH + 1),
  localparam int CMPW = ((CW > ROW_WIDTH_W) ? CW : ROW_WIDTH_W) + 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [ROW_WIDTH_W-1:0] cfg_data,
  input  logic                   accept,
  input  logic                   frame_start,
  output logic [ELEM_SIZE_W-1:0] element_size,
  output logic [AW-1:0]          rd_addr,
  output pos_t                   pos
);

  logic [ROW_WIDTH_W-1:0] row_width;
  logic [CW-1:0]          col;
  logic                   first_row;

  logic [CW-1:0]   col_eff;
  logic            first_eff;
  logic [CMPW-1:0] row_ext;
  logic [CMPW-1:0] max_ext;
  logic [CMPW-1:0] w_eff;
  logic [CMPW-1:0] col_ext;
  logic [CMPW-1:0] col_inc;
  logic            in_range;
  logic [CW-1:0]   col_next;
  logic            first_row_next;

  always_comb begin
    col_eff   = frame_start ? '0 : col;
    first_eff = frame_start | first_row;
    row_ext   = CMPW'(row_width);
    max_ext   = CMPW'(MAX_ROW_WIDTH);
    w_eff     = (row_ext > max_ext) ? max_ext : row_ext;
    col_ext   = CMPW'(col_eff);
    col_inc   = col_ext + CMPW'(1);
    in_range  = col_ext < max_ext;

    pos.use_n = !first_eff && in_range;
    pos.use_w = col_eff != '0;
    pos.store = (w_eff != '0) && in_range;
    rd_addr   = col_eff[AW-1:0];

    if (w_eff == '0) begin
      col_next       = CW'(1);
      first_row_next = first_eff;
    end else if (col_inc >= w_eff) begin
      col_next       = '0;
      first_row_next = 1'b0;
    end else begin
      col_next       = col_inc[CW-1:0];
      first_row_next = first_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      element_size <= '0;
      row_width    <= '0;
      col          <= '0;
      first_row    <= 1'b1;
    end else begin
      if (cfg_valid) begin
        case (reg_index_t'(cfg_index))
          REG_ELEMENT_SIZE: element_size <= cfg_data[ELEM_SIZE_W-1:0];
          REG_ROW_WIDTH:    row_width    <= cfg_data;
          default:          ;
        endcase
      end
      if (accept) begin
        col       <= col_next;
        first_row <= first_row_next;
      end
    end
  end

  a_col_bounded: assert property (@(posedge clk) disable iff (rst)
    CMPW'(col) <= CMPW'(MAX_ROW_WIDTH) || MAX_ROW_WIDTH == 1)
    else $error("column beyond row capacity");

  a_row_wrap: assert property (@(posedge clk) disable iff (rst)
    accept && w_eff != '0 && col_inc >= w_eff |=> col == '0 && !first_row)
    else $error("row end did not wrap column");

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    accept && frame_start |-> !pos.use_n && !pos.use_w)
    else $error("frame start used neighbor values");

endmodule

>>> design/avgpd_dp.sv
module avgpd_dp
  import avgpd_pkg::*;
#(
  parameter int AW = 12
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [DATA_W-1:0]      residual,
  input  pos_t                   pos,
  input  logic [AW-1:0]          rd_addr,
  input  logic [ELEM_SIZE_W-1:0] element_size,
  input  logic [DATA_W-1:0]      ram_rd_data,
  output logic                   wr_en,
  output logic [AW-1:0]          wr_addr,
  output logic [DATA_W-1:0]      wr_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [DATA_W-1:0]      pixel_value
);

  logic              s1_valid;
  logic [DATA_W-1:0] s1_res;
  pos_t              s1_pos;
  logic [AW-1:0]     s1_addr;
  logic              byp_hit;
  logic [DATA_W-1:0] byp_data;
  logic [DATA_W-1:0] west;

  logic              accept;
  logic              s1_adv;
  logic [DATA_W-1:0] mask;
  logic [DATA_W-1:0] nv;
  logic [DATA_W-1:0] wv;
  logic [DATA_W-1:0] pred;
  logic [DATA_W-1:0] pix;

  assign in_stall = s1_valid && out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign s1_adv   = s1_valid && (!out_valid || !out_stall);

  always_comb begin
    mask = width_mask(element_size);
    // north comes from the word written on the same edge as the read, if any
    nv   = s1_pos.use_n ? ((byp_hit ? byp_data : ram_rd_data) & mask) : '0;
    wv   = s1_pos.use_w ? (west & mask) : '0;
    pred = ((wv >> 1) + (nv >> 1) + DATA_W'(wv[0] & nv[0])) & mask;
    pix  = ((s1_res & mask) + pred) & mask;
  end

  assign wr_en   = s1_adv && s1_pos.store;
  assign wr_addr = s1_addr;
  assign wr_data = pix;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      byp_hit   <= 1'b0;
      west      <= '0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
        byp_hit  <= wr_en && (wr_addr == rd_addr);
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        west      <= pix;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_res   <= residual;
      s1_pos   <= pos;
      s1_addr  <= rd_addr;
      byp_data <= pix;
    end
    if (s1_adv) begin
      pixel_value <= pix;
    end
  end

  a_upper_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pixel_value & ~width_mask(element_size)) == '0)
    else $error("word has bits above element width");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid)
    else $error("input stalled with room in pipeline");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> out_valid && pixel_value == $past(pix))
    else $error("result not registered");

  a_bypass: assert property (@(posedge clk) disable iff (rst)
    accept && wr_en && wr_addr == rd_addr |=> byp_hit && s1_valid)
    else $error("same-address write not forwarded");

endmodule

>>> design/average_predictor_decode_top.sv
// Inverse average predictor: each residual word becomes residual + floor((W+N)/2) at the
// configured element width. One word is accepted per cycle while the input is not stalled; each
// accepted word passes through the line store read stage and then the add into the output
// register. The previous row sits in a single MAX_ROW_WIDTH x 64 RAM that is read when a word
// is accepted and written when its result is registered; a write to the address being read on
// the same edge is forwarded. Input stalls only while the output is stalled with both stages
// full. Configuration writes are always taken and must only be issued while the block is idle.
module average_predictor_decode_top
  import avgpd_pkg::*;
#(
  parameter int MAX_ROW_WIDTH = DEFAULT_MAX_ROW_WIDTH,
  localparam int AW = (MAX_ROW_WIDTH > 1) ? $clog2(MAX_ROW_WIDTH) : 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [ROW_WIDTH_W-1:0] cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [DATA_W-1:0]      residual,
  input  logic                   frame_start,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [DATA_W-1:0]      pixel_value
);

  logic                   accept;
  logic [ELEM_SIZE_W-1:0] element_size;
  logic [AW-1:0]          rd_addr;
  pos_t                   pos;
  logic [DATA_W-1:0]      ram_rd_data;
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [DATA_W-1:0]      wr_data;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;

  avgpd_ctrl #(
    .MAX_ROW_WIDTH(MAX_ROW_WIDTH)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .accept      (accept),
    .frame_start (frame_start),
    .element_size(element_size),
    .rd_addr     (rd_addr),
    .pos         (pos)
  );

  avgpd_ram #(
    .WIDTH(DATA_W),
    .DEPTH(MAX_ROW_WIDTH)
  ) u_line_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (accept),
    .rd_addr(rd_addr),
    .rd_data(ram_rd_data)
  );

  avgpd_dp #(
    .AW(AW)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .residual    (residual),
    .pos         (pos),
    .rd_addr     (rd_addr),
    .element_size(element_size),
    .ram_rd_data (ram_rd_data),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel_value (pixel_value)
  );

endmodule
